// File: hw/rtl/d4lw_pkg.sv
// Package for the D4 lifting wavelet core: widths, lifting constants,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package d4lw_pkg;

    localparam int DATA_W    = 32;
    localparam int COEF_W    = 16;
    localparam int ACC_W     = DATA_W + COEF_W;
    localparam int FRAC_BITS = 12;

    localparam logic signed [COEF_W-1:0] C_ROOT3  = 16'sd7094;
    localparam logic signed [COEF_W-1:0] C_R3O4   = 16'sd1774;
    localparam logic signed [COEF_W-1:0] C_R3M2O4 = -16'sd275;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MULA,
        S_DIFF,
        S_MAC1,
        S_MAC2,
        S_LOW,
        S_MULL,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        COEF_ROOT3,
        COEF_R3O4,
        COEF_R3M2O4
    } t_coef;

    typedef enum logic [1:0] {
        MSRC_A,
        MSRC_HIGH,
        MSRC_D,
        MSRC_LOW
    } t_msrc;

    typedef struct packed {
        logic  latch_in;
        logic  mac_en;
        logic  mac_add;
        t_coef coef;
        t_msrc msrc;
        logic  load_d;
        logic  load_lo;
        logic  load_out;
        logic  store_held;
        logic  store_prior_in;
        logic  store_prior_lo;
        logic  inverse;
        logic  tail;
        logic  row_start;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: hw/rtl/d4lw_datapath.sv
// Datapath of the D4 lifting wavelet core: input latch, shared constant MAC,
// held pair, prior input or low and the output register. Depends on d4lw_pkg.
`default_nettype none

module d4lw_datapath (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire d4lw_pkg::t_dp_cmd                   i_cmd,
    output d4lw_pkg::t_dp_sts                        o_sts,
    input  wire logic signed [d4lw_pkg::DATA_W-1:0]  i_sample_a,
    input  wire logic signed [d4lw_pkg::DATA_W-1:0]  i_sample_b,
    input  wire logic                                i_last_pair,
    output logic signed [d4lw_pkg::DATA_W-1:0]       o_result_a,
    output logic signed [d4lw_pkg::DATA_W-1:0]       o_result_b,
    output logic                                     o_row_end,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall
);

    logic signed [d4lw_pkg::DATA_W-1:0] r_a, r_b, r_d, r_lo;
    logic signed [d4lw_pkg::DATA_W-1:0] r_held_first, r_held_high, r_prior;
    logic signed [d4lw_pkg::DATA_W-1:0] r_out_a, r_out_b;
    logic                               r_last, r_out_end, r_out_valid;
    logic signed [d4lw_pkg::ACC_W-1:0]  r_acc;

    logic signed [d4lw_pkg::DATA_W-1:0] fsel, hsel, acc_q, m_x;
    logic signed [d4lw_pkg::DATA_W-1:0] diff_val, lo_val, hi_val;
    logic signed [d4lw_pkg::COEF_W-1:0] m_c;
    logic signed [d4lw_pkg::ACC_W-1:0]  prod;

    assign fsel  = i_cmd.tail ? r_a : r_held_first;
    assign hsel  = i_cmd.tail ? r_d : r_held_high;
    assign acc_q = r_acc[d4lw_pkg::FRAC_BITS +: d4lw_pkg::DATA_W];

    always_comb begin
        unique case (i_cmd.msrc)
            d4lw_pkg::MSRC_A:    m_x = r_a;
            d4lw_pkg::MSRC_HIGH: m_x = hsel;
            d4lw_pkg::MSRC_D:    m_x = r_d;
            d4lw_pkg::MSRC_LOW:  m_x = r_lo;
            default:             m_x = r_a;
        endcase
    end

    always_comb begin
        unique case (i_cmd.coef)
            d4lw_pkg::COEF_ROOT3:  m_c = d4lw_pkg::C_ROOT3;
            d4lw_pkg::COEF_R3O4:   m_c = d4lw_pkg::C_R3O4;
            d4lw_pkg::COEF_R3M2O4: m_c = d4lw_pkg::C_R3M2O4;
            default:               m_c = d4lw_pkg::C_ROOT3;
        endcase
    end

    assign prod = m_x * m_c;

    assign diff_val = i_cmd.inverse ? r_b - (i_cmd.row_start ? r_a : r_prior)
                                    : r_b - acc_q;
    assign lo_val   = i_cmd.inverse ? fsel - acc_q : fsel + acc_q;
    assign hi_val   = i_cmd.inverse ? hsel + acc_q
                                    : hsel + (i_cmd.row_start ? r_lo : r_prior);

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_a    <= i_sample_a;
            r_b    <= i_sample_b;
            r_last <= i_last_pair;
        end
        if (i_cmd.mac_en) begin
            r_acc <= (i_cmd.mac_add ? r_acc : '0) + prod;
        end
        if (i_cmd.load_d) begin
            r_d <= diff_val;
        end
        if (i_cmd.load_lo) begin
            r_lo <= lo_val;
        end
        if (i_cmd.store_held) begin
            r_held_first <= r_a;
            r_held_high  <= i_cmd.load_d ? diff_val : r_d;
        end
        if (i_cmd.store_prior_in) begin
            r_prior <= r_a;
        end else if (i_cmd.store_prior_lo) begin
            r_prior <= r_lo;
        end
        if (i_cmd.load_out) begin
            r_out_a   <= r_lo;
            r_out_b   <= hi_val;
            r_out_end <= i_cmd.tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.last     = r_last;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_result_a  = r_out_a;
    assign o_result_b  = r_out_b;
    assign o_row_end   = r_out_end;
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: hw/rtl/d4lw_ctrl.sv
// Controller of the D4 lifting wavelet core: sequences the shared MAC steps
// and keeps mode and row flags. Depends on d4lw_pkg.
`default_nettype none

module d4lw_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_wdata,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire d4lw_pkg::t_dp_sts i_sts,
    output d4lw_pkg::t_dp_cmd      o_cmd
);

    d4lw_pkg::t_state r_state, n_state;
    logic r_inverse, n_inverse;
    logic r_pending, n_pending;
    logic r_start, n_start;
    logic r_tail, n_tail;

    logic accept;

    assign accept = (r_state == d4lw_pkg::S_IDLE) && i_in_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            d4lw_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = r_inverse ? d4lw_pkg::S_DIFF : d4lw_pkg::S_MULA;
                end
            end
            d4lw_pkg::S_MULA: n_state = d4lw_pkg::S_DIFF;
            d4lw_pkg::S_DIFF: begin
                n_state = (r_pending || i_sts.last) ? d4lw_pkg::S_MAC1 : d4lw_pkg::S_IDLE;
            end
            d4lw_pkg::S_MAC1: n_state = d4lw_pkg::S_MAC2;
            d4lw_pkg::S_MAC2: n_state = d4lw_pkg::S_LOW;
            d4lw_pkg::S_LOW:  n_state = r_inverse ? d4lw_pkg::S_MULL : d4lw_pkg::S_OUT;
            d4lw_pkg::S_MULL: n_state = d4lw_pkg::S_OUT;
            d4lw_pkg::S_OUT: begin
                if (i_sts.out_free) begin
                    n_state = (!r_tail && i_sts.last) ? d4lw_pkg::S_MAC1 : d4lw_pkg::S_IDLE;
                end
            end
            default: n_state = d4lw_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_inverse = r_inverse;
        n_pending = r_pending;
        n_start   = r_start;
        n_tail    = r_tail;
        if (i_cfg_we) begin
            n_inverse = i_cfg_wdata;
            n_pending = 1'b0;
            n_start   = 1'b1;
            n_tail    = 1'b0;
        end else begin
            unique case (r_state)
                d4lw_pkg::S_IDLE: begin
                    if (i_in_valid) begin
                        n_tail = 1'b0;
                    end
                end
                d4lw_pkg::S_DIFF: begin
                    if (r_inverse) begin
                        n_start = 1'b0;
                    end
                    if (i_sts.last) begin
                        n_tail = !r_pending;
                    end else if (!r_pending) begin
                        n_pending = 1'b1;
                    end
                end
                d4lw_pkg::S_OUT: begin
                    if (i_sts.out_free) begin
                        n_start = r_tail;
                        if (r_tail) begin
                            n_pending = 1'b0;
                        end else if (i_sts.last) begin
                            n_tail = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_cmd                = '0;
        o_cmd.coef           = d4lw_pkg::COEF_ROOT3;
        o_cmd.msrc           = d4lw_pkg::MSRC_A;
        o_cmd.inverse        = r_inverse;
        o_cmd.tail           = r_tail;
        o_cmd.row_start      = r_start;
        o_cmd.latch_in       = accept;
        unique case (r_state)
            d4lw_pkg::S_IDLE: begin
            end
            d4lw_pkg::S_MULA: begin
                o_cmd.mac_en = 1'b1;
            end
            d4lw_pkg::S_DIFF: begin
                o_cmd.load_d         = 1'b1;
                o_cmd.store_prior_in = r_inverse;
            end
            d4lw_pkg::S_MAC1: begin
                o_cmd.mac_en = 1'b1;
                o_cmd.coef   = d4lw_pkg::COEF_R3O4;
                o_cmd.msrc   = d4lw_pkg::MSRC_HIGH;
            end
            d4lw_pkg::S_MAC2: begin
                o_cmd.mac_en  = 1'b1;
                o_cmd.mac_add = 1'b1;
                o_cmd.coef    = d4lw_pkg::COEF_R3M2O4;
                o_cmd.msrc    = d4lw_pkg::MSRC_D;
            end
            d4lw_pkg::S_LOW: begin
                o_cmd.load_lo = 1'b1;
            end
            d4lw_pkg::S_MULL: begin
                o_cmd.mac_en = 1'b1;
                o_cmd.msrc   = d4lw_pkg::MSRC_LOW;
            end
            d4lw_pkg::S_OUT: begin
                o_cmd.load_out       = i_sts.out_free;
                o_cmd.store_prior_lo = i_sts.out_free && !r_inverse;
                o_cmd.store_held     = i_sts.out_free && !r_tail && !i_sts.last;
            end
            default: begin
            end
        endcase
        if (r_state == d4lw_pkg::S_DIFF && !r_pending && !i_sts.last) begin
            o_cmd.store_held = 1'b1;
        end
    end

    assign o_in_stall = (r_state != d4lw_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= d4lw_pkg::S_IDLE;
            r_inverse <= 1'b0;
            r_pending <= 1'b0;
            r_start   <= 1'b1;
            r_tail    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_inverse <= n_inverse;
            r_pending <= n_pending;
            r_start   <= n_start;
            r_tail    <= n_tail;
        end
    end

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !i_cfg_we |=> r_state != d4lw_pkg::S_IDLE)
        else $error("accepted request did not start work");

    a_load_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_sts.out_free)
        else $error("output register overwritten");

    a_tail_needs_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail && r_state != d4lw_pkg::S_IDLE |-> i_sts.last)
        else $error("row end without final pair");

    a_tail_closes_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == d4lw_pkg::S_OUT && i_sts.out_free && r_tail && !i_cfg_we
        |=> !r_pending && r_start && r_state == d4lw_pkg::S_IDLE)
        else $error("row end did not reset row flags");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/d4_lifting_wavelet_core.sv
// Top level of the integer D4 lifting wavelet core (forward and inverse).
// Depends on d4lw_pkg, d4lw_ctrl and d4lw_datapath.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+------------------------------------
//   input    | i_in_valid / o_in_stall  | i_sample_a, i_sample_b, i_last_pair
//   output   | o_out_valid / i_out_stall| o_result_a, o_result_b, o_row_end
//   config   | i_cfg_we                 | i_cfg_wdata (inverse mode)
//
// The single shared constant multiplier, used two or three times per output pair,
// sets how long a pair takes: a pair that is only held is shortest, and one that
// releases the previous pair, forms a one-pair row or ends a longer row runs
// through the further MAC, low and output steps of the controller.
// Reset clears mode to forward and starts a new row. An output stall holds the
// controller in its output state once the output register is full.
`default_nettype none

module d4_lifting_wavelet_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic                                i_cfg_wdata,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic signed [d4lw_pkg::DATA_W-1:0]  i_sample_a,
    input  wire logic signed [d4lw_pkg::DATA_W-1:0]  i_sample_b,
    input  wire logic                                i_last_pair,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic signed [d4lw_pkg::DATA_W-1:0]       o_result_a,
    output logic signed [d4lw_pkg::DATA_W-1:0]       o_result_b,
    output logic                                     o_row_end
);

    d4lw_pkg::t_dp_cmd cmd;
    d4lw_pkg::t_dp_sts sts;

    d4lw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    d4lw_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_sample_a  (i_sample_a),
        .i_sample_b  (i_sample_b),
        .i_last_pair (i_last_pair),
        .o_result_a  (o_result_a),
        .o_result_b  (o_result_b),
        .o_row_end   (o_row_end),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire
